@@ hw/rtl/msd_pkg.sv @@
// Shared types, constants and codes of the multi-source shortest distance engine.
package msd_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int VERT_BITS    = 6;
   localparam int CNT_BITS     = 7;
   localparam int MAX_EDGES    = 256;
   localparam int EDGE_BITS    = 8;
   localparam int ETOT_BITS    = 9;
   localparam int WEIGHT_BITS  = 16;
   localparam int DIST_BITS    = 24;
   localparam int OUT_BITS     = 17;

   localparam logic [DIST_BITS-1:0] DIST_INF     = 24'd10000000;
   localparam logic [DIST_BITS-1:0] DIST_CAP     = 24'd100000;
   localparam logic [CNT_BITS-1:0]  VCOUNT_RESET = 7'd64;
   localparam logic [CNT_BITS-1:0]  VCOUNT_MAX   = 7'd64;
   localparam logic [ETOT_BITS-1:0] EDGE_LIMIT   = 9'd256;

   typedef enum logic [1:0] {
      FUNC_ADD_EDGE   = 2'd0,
      FUNC_ADD_SOURCE = 2'd1,
      FUNC_RUN        = 2'd2,
      FUNC_CLEAR      = 2'd3
   } func_type;

   typedef struct packed {
      func_type         func;
      logic [5:0]       node_a;
      logic [5:0]       node_b;
      logic [15:0]      link_weight;
   } req_type;

   typedef struct packed {
      logic [5:0]       vertex;
      logic [16:0]      distance;
      logic             last;
   } rsp_type;

   typedef struct packed {
      logic [VERT_BITS-1:0]   node_a;
      logic [VERT_BITS-1:0]   node_b;
      logic [WEIGHT_BITS-1:0] weight;
   } edge_type;

   typedef struct packed {
      logic load;
      logic v_clr;
      logic e_clr;
      logic init_wr;
      logic scan;
      logic pick;
      logic edge_rd;
      logic edge_chk;
      logic edge_upd;
      logic out_rd;
      logic out_emit;
   } cmd_type;

   typedef struct packed {
      logic v_last;
      logic e_last;
      logic e_none;
      logic found;
   } sts_type;

endpackage

@@ hw/rtl/msd_datapath.sv @@
// Datapath: edge and distance memories, counters, minimum search and relaxation.
module msd_datapath (
   input  logic             clock,
   input  logic             reset,
   input  msd_pkg::cmd_type cmd,
   output msd_pkg::sts_type sts,
   input  msd_pkg::req_type req_data,
   input  logic             csr_we,
   input  logic [6:0]       csr_wdata,
   output logic             rsp_strobe,
   output msd_pkg::rsp_type rsp_data
);
   import msd_pkg::*;

   edge_type             edge_mem [MAX_EDGES];
   logic [DIST_BITS-1:0] dist_mem [MAX_VERTICES];

   logic [CNT_BITS-1:0]     vcount_ff;
   logic [CNT_BITS-1:0]     n_eff;
   logic [ETOT_BITS-1:0]    etotal_ff;
   logic [MAX_VERTICES-1:0] src_ff;
   logic [MAX_VERTICES-1:0] settled_ff;
   logic [VERT_BITS-1:0]    v_cnt_ff;
   logic [EDGE_BITS-1:0]    e_cnt_ff;
   edge_type                edge_rd_ff;
   logic [DIST_BITS-1:0]    dist_rd_ff;
   logic                    scan_vld_ff;
   logic [VERT_BITS-1:0]    idx_ff;
   logic [DIST_BITS-1:0]    best_ff;
   logic [VERT_BITS-1:0]    pick_ff;
   logic                    found_ff;
   logic                    ok_ff;
   logic [VERT_BITS-1:0]    other_ff;
   logic [DIST_BITS-1:0]    cand_ff;
   logic                    rsp_strobe_ff;
   rsp_type                 rsp_ff;

   logic                    dist_we;
   logic [VERT_BITS-1:0]    dist_wa;
   logic [DIST_BITS-1:0]    dist_wd;
   logic [VERT_BITS-1:0]    dist_ra;
   logic                    hit_a;
   logic                    hit_b;
   logic [VERT_BITS-1:0]    other_in;
   logic                    ok_in;
   logic [DIST_BITS-1:0]    cand_in;
   logic [DIST_BITS-1:0]    sat_dist;

   always_comb begin
      if (vcount_ff == '0) begin
         n_eff = 7'd1;
      end else if (vcount_ff > VCOUNT_MAX) begin
         n_eff = VCOUNT_MAX;
      end else begin
         n_eff = vcount_ff;
      end
   end

   assign sts.v_last = ({1'b0, v_cnt_ff} == (n_eff - 7'd1));
   assign sts.e_last = ({1'b0, e_cnt_ff} == (etotal_ff - 9'd1));
   assign sts.e_none = (etotal_ff == '0);
   assign sts.found  = found_ff;

   // Relaxation candidate: the neighbor of the picked vertex on this edge.
   always_comb begin
      hit_a    = (edge_rd_ff.node_a == pick_ff);
      hit_b    = (edge_rd_ff.node_b == pick_ff);
      other_in = hit_a ? edge_rd_ff.node_b : edge_rd_ff.node_a;
      ok_in    = (hit_a || hit_b) && ({1'b0, other_in} < n_eff);
      cand_in  = best_ff + {{(DIST_BITS-WEIGHT_BITS){1'b0}}, edge_rd_ff.weight};
   end

   always_comb begin
      dist_we = 1'b0;
      dist_wa = v_cnt_ff;
      dist_wd = src_ff[v_cnt_ff] ? '0 : DIST_INF;
      if (cmd.init_wr) begin
         dist_we = 1'b1;
      end else if (cmd.edge_upd && ok_ff && (cand_ff < dist_rd_ff)) begin
         dist_we = 1'b1;
         dist_wa = other_ff;
         dist_wd = cand_ff;
      end
      dist_ra = cmd.edge_chk ? other_in : v_cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (dist_we) begin
         dist_mem[dist_wa] <= dist_wd;
      end
      dist_rd_ff <= dist_mem[dist_ra];
      if (cmd.load && (req_data.func == FUNC_ADD_EDGE) && (etotal_ff < EDGE_LIMIT)) begin
         edge_mem[etotal_ff[EDGE_BITS-1:0]] <= '{req_data.node_a, req_data.node_b,
                                                req_data.link_weight};
      end
      edge_rd_ff <= edge_mem[e_cnt_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff     <= VCOUNT_RESET;
         etotal_ff     <= '0;
         src_ff        <= '0;
         settled_ff    <= '0;
         v_cnt_ff      <= '0;
         e_cnt_ff      <= '0;
         scan_vld_ff   <= 1'b0;
         found_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            vcount_ff <= csr_wdata;
         end
         if (cmd.load) begin
            case (req_data.func)
               FUNC_ADD_EDGE: begin
                  if (etotal_ff < EDGE_LIMIT) begin
                     etotal_ff <= etotal_ff + 9'd1;
                  end
               end
               FUNC_ADD_SOURCE: begin
                  src_ff[req_data.node_a] <= 1'b1;
               end
               FUNC_CLEAR: begin
                  etotal_ff <= '0;
                  src_ff    <= '0;
               end
               FUNC_RUN: begin
                  settled_ff <= '0;
               end
               default: begin
               end
            endcase
         end
         if (cmd.v_clr) begin
            v_cnt_ff <= '0;
         end else if (cmd.init_wr || cmd.scan || cmd.out_emit) begin
            v_cnt_ff <= v_cnt_ff + 6'd1;
         end
         if (cmd.e_clr) begin
            e_cnt_ff <= '0;
         end else if (cmd.edge_upd) begin
            e_cnt_ff <= e_cnt_ff + 8'd1;
         end
         scan_vld_ff <= cmd.scan;
         if (scan_vld_ff && !settled_ff[idx_ff] && (dist_rd_ff < best_ff)) begin
            found_ff <= 1'b1;
         end else if (cmd.scan && (v_cnt_ff == '0)) begin
            found_ff <= 1'b0;
         end
         if (cmd.pick && found_ff) begin
            settled_ff[pick_ff] <= 1'b1;
         end
         rsp_strobe_ff <= cmd.out_emit;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= v_cnt_ff;
      if (scan_vld_ff && !settled_ff[idx_ff] && (dist_rd_ff < best_ff)) begin
         best_ff <= dist_rd_ff;
         pick_ff <= idx_ff;
      end else if (cmd.scan && (v_cnt_ff == '0)) begin
         best_ff <= DIST_INF;
      end
      ok_ff    <= ok_in;
      other_ff <= other_in;
      cand_ff  <= cand_in;
      if (cmd.out_emit) begin
         rsp_ff.vertex   <= v_cnt_ff;
         rsp_ff.distance <= sat_dist[OUT_BITS-1:0];
         rsp_ff.last     <= sts.v_last;
      end
   end

   assign sat_dist   = (dist_rd_ff > DIST_CAP) ? DIST_CAP : dist_rd_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   a_edge_total_bound: assert property (@(posedge clock) disable iff (reset)
      etotal_ff <= EDGE_LIMIT)
      else $error("edge count beyond capacity");

   a_dist_write_in_range: assert property (@(posedge clock) disable iff (reset)
      dist_we |-> ({1'b0, dist_wa} < n_eff))
      else $error("distance write outside active vertices");

   a_pick_unsettled: assert property (@(posedge clock) disable iff (reset)
      (cmd.pick && found_ff) |-> !settled_ff[pick_ff])
      else $error("picked vertex already settled");

endmodule

@@ hw/rtl/msd_controller.sv @@
// Controller: sequences initialization, minimum scans, edge relaxation and output.
module msd_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  msd_pkg::func_type func,
   output logic              busy,
   output msd_pkg::cmd_type  cmd,
   input  msd_pkg::sts_type  sts
);
   import msd_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_INIT  = 10'b0000000010,
      ST_SCAN  = 10'b0000000100,
      ST_SLAST = 10'b0000001000,
      ST_PICK  = 10'b0000010000,
      ST_ERD   = 10'b0000100000,
      ST_ECHK  = 10'b0001000000,
      ST_EUPD  = 10'b0010000000,
      ST_ORD   = 10'b0100000000,
      ST_OEMIT = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (func == FUNC_RUN) begin
                  cmd.v_clr = 1'b1;
                  state_in  = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            cmd.init_wr = 1'b1;
            if (sts.v_last) begin
               cmd.v_clr = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.v_last) begin
               state_in = ST_SLAST;
            end
         end
         ST_SLAST: begin
            state_in = ST_PICK;
         end
         ST_PICK: begin
            cmd.pick  = 1'b1;
            cmd.v_clr = 1'b1;
            if (!sts.found) begin
               state_in = ST_ORD;
            end else if (sts.e_none) begin
               state_in = ST_SCAN;
            end else begin
               cmd.e_clr = 1'b1;
               state_in  = ST_ERD;
            end
         end
         ST_ERD: begin
            cmd.edge_rd = 1'b1;
            state_in    = ST_ECHK;
         end
         ST_ECHK: begin
            cmd.edge_chk = 1'b1;
            state_in     = ST_EUPD;
         end
         ST_EUPD: begin
            cmd.edge_upd = 1'b1;
            if (sts.e_last) begin
               cmd.v_clr = 1'b1;
               state_in  = ST_SCAN;
            end else begin
               state_in = ST_ERD;
            end
         end
         ST_ORD: begin
            cmd.out_rd = 1'b1;
            state_in   = ST_OEMIT;
         end
         ST_OEMIT: begin
            cmd.out_emit = 1'b1;
            state_in     = sts.v_last ? ST_IDLE : ST_ORD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   a_load_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !busy)
      else $error("request taken while busy");

   a_emit_after_read: assert property (@(posedge clock) disable iff (reset)
      cmd.out_emit |-> $past(cmd.out_rd))
      else $error("result emitted without a distance read");

   a_relax_sequence: assert property (@(posedge clock) disable iff (reset)
      cmd.edge_upd |-> $past(cmd.edge_chk, 1) && $past(cmd.edge_rd, 2))
      else $error("edge update out of sequence");

endmodule

@@ hw/rtl/multi_source_shortest_distance.sv @@
// Top level of the multi-source shortest distance engine.
//
// Requests are taken when start is high and busy is low. Add edge, add source and
// clear requests never raise busy; edges past the 256-entry store are dropped.
// A run request holds busy while a controller steps a datapath through a Dijkstra
// search with every source at distance zero: one initialization write per active
// vertex, then per settled (reachable) vertex a serial minimum scan over the distance
// memory, the close of the scan, the pick, and a read, check and update of each stored
// edge through the single read port of the edge and distance memories; a final scan
// finds nothing left to settle, and output reads and then emits each vertex in turn.
// The last result appears in the same cycle in which busy falls.
// Each result appears for exactly one cycle with rsp_strobe high, in ascending vertex
// order, with last set on the final vertex; the receiver cannot stall results, so
// they must be captured as they come. Unreached vertices report 100000, as do any
// distances at or above it. The vertex count register is written through csr_we and
// csr_wdata and must only change while busy is low; 0 acts as 1 and values above 64
// act as 64.
module multi_source_shortest_distance (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  msd_pkg::req_type req_data,
   output logic             rsp_strobe,
   output msd_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [6:0]       csr_wdata
);
   import msd_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // The controller only sequences; all storage and arithmetic sit in the datapath.
   msd_controller u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .func  (req_data.func),
      .busy  (busy),
      .cmd   (cmd),
      .sts   (sts)
   );

   msd_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_data   (req_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

@@ tb/multi_source_shortest_distance_test.sv @@
// Self-checking testbench for the multi-source shortest distance engine.
module multi_source_shortest_distance_test;
   import msd_pkg::*;

   localparam int IDLE_LIMIT = 300000;

   // Keeps a private copy of the graph and predicts every distance report of a run.
   class shortest_distance_board;
      edge_type    edge_list[MAX_EDGES];
      int unsigned edge_cnt;
      logic [63:0] source_set;
      logic [6:0]  vertex_limit;
      rsp_type     pending_distances[$];
      int          errors;

      function new();
         edge_cnt     = 0;
         source_set   = '0;
         vertex_limit = 7'd64;
         errors       = 0;
      endfunction

      function void set_count(logic [6:0] value);
         vertex_limit = value;
      endfunction

      // Runs the search exactly as the engine orders it and queues one report per vertex.
      function void predict_run();
         int unsigned vert_dist[MAX_VERTICES];
         logic [63:0] settled;
         int unsigned n, best, pick, cand;
         rsp_type     r;
         n = (vertex_limit == 0) ? 1 : (vertex_limit > 64) ? 64 : vertex_limit;
         settled = '0;
         for (int v = 0; v < n; v++)
            vert_dist[v] = source_set[v] ? 0 : 10000000;
         for (int round = 0; round < n; round++) begin
            best = 10000000;
            pick = n;
            for (int v = 0; v < n; v++)
               if (!settled[v] && vert_dist[v] < best) begin
                  best = vert_dist[v];
                  pick = v;
               end
            if (pick >= n) break;
            settled[pick] = 1'b1;
            for (int e = 0; e < edge_cnt; e++) begin
               int unsigned a, b;
               a = edge_list[e].node_a;
               b = edge_list[e].node_b;
               if (a < n && b < n) begin
                  cand = vert_dist[pick] + edge_list[e].weight;
                  if (a == pick && settled[a] && cand < vert_dist[b]) vert_dist[b] = cand;
                  cand = vert_dist[pick] + edge_list[e].weight;
                  if (b == pick && settled[b] && cand < vert_dist[a]) vert_dist[a] = cand;
               end
            end
         end
         for (int v = 0; v < n; v++) begin
            r.vertex   = v[5:0];
            r.distance = (vert_dist[v] > 100000) ? 17'd100000 : vert_dist[v][16:0];
            r.last     = (v + 1 == n);
            pending_distances = {pending_distances, r};
         end
      endfunction

      function void note_request(req_type q);
         case (q.func)
            FUNC_ADD_EDGE: begin
               if (edge_cnt < MAX_EDGES) begin
                  edge_list[edge_cnt] = '{q.node_a, q.node_b, q.link_weight};
                  edge_cnt++;
               end
            end
            FUNC_ADD_SOURCE: source_set[q.node_a] = 1'b1;
            FUNC_CLEAR: begin
               edge_cnt   = 0;
               source_set = '0;
            end
            default: predict_run();
         endcase
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending_distances.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %p", $time, got);
            errors++;
            return;
         end
         want = pending_distances.pop_front();
         if (got.vertex !== want.vertex) begin
            $display("%0t: vertex expected %0d actual %0d", $time, want.vertex, got.vertex);
            errors++;
         end
         if (got.distance !== want.distance) begin
            $display("%0t: distance of vertex %0d expected %0d actual %0d", $time,
                     want.vertex, want.distance, got.distance);
            errors++;
         end
         if (got.last !== want.last) begin
            $display("%0t: last of vertex %0d expected %0d actual %0d", $time,
                     want.vertex, want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;
   logic    csr_we;
   logic [6:0] csr_wdata;

   shortest_distance_board board;
   int idle_cycles;

   multi_source_shortest_distance i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Results cannot be held off, so every strobe is checked on the edge that ends it.
   // The watchdog counts edges at which neither a request nor a result moves; a full
   // run over 64 vertices and a full edge store stays well below the limit.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) board.check_result(rsp_data);
         if (rsp_strobe || (start && !busy)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("multi_source_shortest_distance verification failed");
            $finish;
         end
      end
   end

   // Presents one request and holds it until the engine takes it. Called at a clock edge.
   task automatic send(func_type f, logic [5:0] a, logic [5:0] b, logic [15:0] w);
      req_type q;
      q.func        = f;
      q.node_a      = a;
      q.node_b      = b;
      q.link_weight = w;
      start    <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_request(q);
   endtask

   task automatic pause(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Sender burst control: after a random burst, it rests for a random gap in three of four cases.
   int burst_left;
   task automatic maybe_gap();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 8);
         if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 6));
      end
   endtask

   // Waits until the engine is idle with nothing outstanding; write_count uses it before writing the count.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (board.pending_distances.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_count(logic [6:0] value);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      board.set_count(value);
   endtask

   // One random phase: a fresh graph of the given size, mostly well formed, then a run.
   task automatic random_phase(logic [6:0] count, int edges);
      int unsigned n, top;
      logic [15:0] w;
      write_count(count);
      n   = (count == 0) ? 1 : (count > 64) ? 64 : count;
      top = (n + 1 > 63) ? 63 : n + 1;
      send(FUNC_CLEAR, 6'($urandom), 6'($urandom), 16'($urandom));
      for (int i = 0; i < edges; i++) begin
         w = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 200));
         if ($urandom_range(0, 9) == 0) begin
            // Noise: any request kind with any content.
            send(func_type'($urandom_range(0, 3)), 6'($urandom), 6'($urandom), w);
         end else begin
            send(FUNC_ADD_EDGE, 6'($urandom_range(0, top)), 6'($urandom_range(0, top)), w);
         end
         maybe_gap();
      end
      repeat ($urandom_range(1, 3)) begin
         send(FUNC_ADD_SOURCE, 6'($urandom_range(0, top)), 6'($urandom), 16'($urandom));
         maybe_gap();
      end
      send(FUNC_RUN, 6'($urandom), 6'($urandom), 16'($urandom));
      maybe_gap();
   endtask

   initial begin
      board       = new();
      idle_cycles = 0;
      burst_left  = 0;
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      csr_we      = 1'b0;
      csr_wdata   = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. A run with no sources reports every vertex unreached.
      write_count(7'd4);
      send(FUNC_RUN, 6'd0, 6'd0, 16'd0);
      // A chain whose second hop pushes the distance past the saturation point.
      send(FUNC_ADD_EDGE, 6'd0, 6'd1, 16'd65535);
      send(FUNC_ADD_EDGE, 6'd1, 6'd2, 16'd65535);
      send(FUNC_ADD_EDGE, 6'd2, 6'd3, 16'd0);
      // Edges and sources beyond the vertex count must be skipped.
      send(FUNC_ADD_EDGE, 6'd63, 6'd3, 16'd1);
      send(FUNC_ADD_EDGE, 6'd3, 6'd63, 16'd1);
      send(FUNC_ADD_SOURCE, 6'd63, 6'd63, 16'hFFFF);
      send(FUNC_RUN, 6'd63, 6'd63, 16'hFFFF);
      send(FUNC_ADD_SOURCE, 6'd0, 6'd0, 16'd0);
      send(FUNC_RUN, 6'd0, 6'd0, 16'd0);
      // A second source makes the nearer one win.
      send(FUNC_ADD_SOURCE, 6'd3, 6'd0, 16'd0);
      send(FUNC_RUN, 6'd0, 6'd0, 16'd0);
      send(FUNC_CLEAR, 6'd0, 6'd0, 16'd0);
      send(FUNC_RUN, 6'd0, 6'd0, 16'd0);
      // A count of zero acts as one vertex.
      write_count(7'd0);
      send(FUNC_ADD_SOURCE, 6'd0, 6'd0, 16'd0);
      send(FUNC_RUN, 6'd0, 6'd0, 16'd0);
      // A count above the limit acts as 64 vertices.
      write_count(7'd127);
      send(FUNC_ADD_EDGE, 6'd0, 6'd63, 16'd7);
      send(FUNC_RUN, 6'd0, 6'd0, 16'd0);
      write_count(7'd64);
      send(FUNC_RUN, 6'd0, 6'd0, 16'd0);

      // Random phases over several counts, extremes among them.
      random_phase(7'd1, 2);
      random_phase(7'd2, 3);
      random_phase(7'd5, 6);
      random_phase(7'd64, 10);
      random_phase(7'd8, 8);
      random_phase(7'($urandom_range(3, 20)), 8);
      random_phase(7'd100, 5);
      random_phase(7'($urandom_range(1, 64)), 6);

      // A small graph over eight vertices.
      write_count(7'd8);
      send(FUNC_CLEAR, 6'd0, 6'd0, 16'd0);
      for (int i = 0; i < 8; i++)
         send(FUNC_ADD_EDGE, 6'($urandom_range(0, 8)), 6'($urandom_range(0, 8)),
              16'($urandom_range(0, 300)));
      send(FUNC_ADD_SOURCE, 6'($urandom_range(0, 7)), 6'd0, 16'd0);
      send(FUNC_RUN, 6'd0, 6'd0, 16'd0);

      // Hold the sender until every report of that run is in, then run once more.
      drain();
      send(FUNC_ADD_SOURCE, 6'($urandom_range(0, 7)), 6'd0, 16'd0);
      send(FUNC_RUN, 6'd0, 6'd0, 16'd0);

      drain();
      repeat (20) @(posedge clock);
      if (board.errors == 0 && board.pending_distances.size() == 0) begin
         $display("multi_source_shortest_distance verification clean");
      end else begin
         $display("multi_source_shortest_distance verification failed");
      end
      $finish;
   end
endmodule
